>>> sv/apfdf_pkg.sv
// Package with the shared constants, types and codes of the audio playout formatter.
package apfdf_pkg;

   localparam int FIFO_DEPTH = 8192;
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

   localparam int SAMPLE_W = 16;
   localparam int ENV_W = 16;
   localparam int LEVEL_W = 14;
   localparam int STEP_W = 16;
   localparam int VOL_W = 16;
   localparam int FILL_W = 14;
   localparam int DAC_W = 16;
   localparam int DAC_LEVEL_W = 12;
   localparam int CMP_W = (OCC_W > LEVEL_W) ? OCC_W : LEVEL_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRIME_LEVEL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_WATER = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_UP_STEP = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_DOWN_STEP = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME = 3'd4;

   localparam logic [LEVEL_W-1:0] PRIME_LEVEL_RESET = 14'd320;
   localparam logic [LEVEL_W-1:0] LOW_WATER_RESET = 14'd40;
   localparam logic [STEP_W-1:0] FADE_UP_RESET = 16'd410;
   localparam logic [STEP_W-1:0] FADE_DOWN_RESET = 16'd410;
   localparam logic [VOL_W-1:0] VOLUME_RESET = 16'd4096;

   localparam logic [ENV_W-1:0] ENV_ONE = 16'd32768;
   localparam logic [DAC_W-1:0] DAC_FLAGS = 16'h3000;
   localparam logic [DAC_LEVEL_W-1:0] MIDSCALE = 12'd2048;
   localparam logic [DAC_LEVEL_W-1:0] LEVEL_MAX = 12'd4095;
   localparam logic signed [32:0] VOL_LIMIT = 33'sd134083510;
   localparam logic signed [32:0] HALF_Q27 = 33'sd134217728;
   localparam logic [40:0] ROUND_Q28 = 41'd134217728;
   localparam logic [47:0] ROUND_Q30 = 48'd536870912;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_TICK = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] prime_level;
      logic [LEVEL_W-1:0] low_water;
      logic [STEP_W-1:0]  fade_up_step;
      logic [STEP_W-1:0]  fade_down_step;
      logic [VOL_W-1:0]   volume;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [ENV_W-1:0]    envelope;
      logic                played;
      logic [FILL_W-1:0]   fill;
   } job_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_READ
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_ENV_MUL,
      BACK_SCALE,
      BACK_ROUND,
      BACK_VOL_MUL,
      BACK_CLAMP,
      BACK_LEVEL
   } back_state_type;

endpackage

>>> sv/apfdf_ram.sv
// Generic single-port-write, registered-read RAM.
module apfdf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/apfdf_queue.sv
// Short queue of tick jobs between the front and back parts.
module apfdf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  apfdf_pkg::job_type push_job,
   input  logic              pop,
   output apfdf_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);
   import apfdf_pkg::*;

   job_type entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = entries_ff[rd_ptr_ff];
   assign full = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Job queue written while full.");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("Job queue read while empty.");
endmodule

>>> sv/apfdf_front.sv
// Front part: takes requests, keeps the sample FIFO control and envelope, issues tick jobs.
module apfdf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  apfdf_pkg::cfg_type             cfg,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [apfdf_pkg::SAMPLE_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,
   output logic                           ram_we,
   output logic [apfdf_pkg::PTR_W-1:0]    ram_waddr,
   output logic [apfdf_pkg::SAMPLE_W-1:0] ram_wdata,
   output logic                           ram_re,
   output logic [apfdf_pkg::PTR_W-1:0]    ram_raddr,
   input  logic [apfdf_pkg::SAMPLE_W-1:0] ram_rdata,
   output logic                           queue_push,
   output apfdf_pkg::job_type             queue_job,
   input  logic                           queue_full
);
   import apfdf_pkg::*;

   front_state_type state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [ENV_W-1:0] env_ff, env_in;
   logic             primed_ff, primed_in;
   logic             played_ff, played_in;

   op_type           op;
   logic             primed_now;
   logic             can_play;
   logic [OCC_W-1:0] occ_dec;
   logic             rise_ok;
   logic [ENV_W-1:0] env_down;
   logic [ENV_W:0]   env_sum;
   logic [ENV_W-1:0] env_up;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff <= '0;
         env_ff <= '0;
         primed_ff <= 1'b0;
         played_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff <= occ_in;
         env_ff <= env_in;
         primed_ff <= primed_in;
         played_ff <= played_in;
      end
   end

   always_comb begin
      op = op_type'(req_tuser);
      primed_now = primed_ff || (CMP_W'(occ_ff) >= CMP_W'(cfg.prime_level));
      can_play = primed_now && (occ_ff != '0);
      occ_dec = occ_ff - 1'b1;
      rise_ok = (CMP_W'(occ_dec) >= CMP_W'(cfg.low_water));
      env_down = (env_ff > cfg.fade_down_step) ? env_ff - cfg.fade_down_step : '0;
      env_sum = (ENV_W+1)'(env_ff) + (ENV_W+1)'(cfg.fade_up_step);
      env_up = (env_sum > (ENV_W+1)'(ENV_ONE)) ? ENV_ONE : ENV_W'(env_sum);

      state_in = state_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in = occ_ff;
      env_in = env_ff;
      primed_in = primed_ff;
      played_in = played_ff;
      req_tready = 1'b0;
      ram_we = 1'b0;
      ram_re = 1'b0;
      queue_push = 1'b0;

      unique case (state_ff)
         FRONT_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (op)
                  OP_PUSH: begin
                     if (occ_ff != OCC_W'(FIFO_DEPTH)) begin
                        ram_we = 1'b1;
                        wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ?
                                    '0 : wr_ptr_ff + 1'b1;
                        occ_in = occ_ff + 1'b1;
                     end
                  end
                  OP_TICK: begin
                     primed_in = primed_now;
                     ram_re = 1'b1;
                     state_in = FRONT_READ;
                     if (can_play) begin
                        rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ?
                                    '0 : rd_ptr_ff + 1'b1;
                        occ_in = occ_dec;
                        env_in = rise_ok ? env_up : env_down;
                        played_in = 1'b1;
                     end else begin
                        env_in = env_down;
                        played_in = 1'b0;
                     end
                  end
                  OP_RESTART: begin
                     wr_ptr_in = '0;
                     rd_ptr_in = '0;
                     occ_in = '0;
                     env_in = '0;
                     primed_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         FRONT_READ: begin
            if (!queue_full) begin
               queue_push = 1'b1;
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   assign ram_waddr = wr_ptr_ff;
   assign ram_wdata = req_tdata;
   assign ram_raddr = rd_ptr_ff;
   assign queue_job = '{sample: ram_rdata, envelope: env_ff, played: played_ff,
                        fill: FILL_W'(occ_ff)};

   assert property (@(posedge clock) disable iff (reset) occ_ff <= OCC_W'(FIFO_DEPTH))
      else $error("FIFO occupancy beyond its depth.");
   assert property (@(posedge clock) disable iff (reset) env_ff <= ENV_ONE)
      else $error("Envelope above full scale.");
   assert property (@(posedge clock) disable iff (reset)
      $fell(primed_ff) |-> $past(req_tvalid && req_tready && req_tuser == OP_RESTART))
      else $error("Primed flag cleared without a restart request.");
endmodule

>>> sv/apfdf_back.sv
// Back part: scales each tick job by envelope and volume and forms the DAC word.
module apfdf_back (
   input  logic                             clock,
   input  logic                             reset,
   input  apfdf_pkg::cfg_type               cfg,
   input  apfdf_pkg::job_type               head_job,
   input  logic                             queue_empty,
   output logic                             queue_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,
   output logic                             rsp_tuser
);
   import apfdf_pkg::*;

   back_state_type state_ff, state_in;
   job_type              job_ff, job_in;
   logic signed [32:0]   prod_ff, prod_in;
   logic                 neg_ff, neg_in;
   logic [46:0]          mag_ff, mag_in;
   logic signed [15:0]   q_ff, q_in;
   logic signed [32:0]   x_ff, x_in;
   logic [28:0]          y_ff, y_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DAC_W-1:0]     rsp_dac_ff, rsp_dac_in;
   logic                 rsp_played_ff, rsp_played_in;
   logic [FILL_W-1:0]    rsp_fill_ff, rsp_fill_in;

   logic signed [47:0]   p_ext;
   logic signed [47:0]   scaled;
   logic [16:0]          r;
   logic signed [32:0]   x_clamped;
   logic [40:0]          t;
   logic [12:0]          v;
   logic [DAC_LEVEL_W-1:0] level;
   logic                 slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      q_ff <= q_in;
      x_ff <= x_in;
      y_ff <= y_in;
      rsp_dac_ff <= rsp_dac_in;
      rsp_played_ff <= rsp_played_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   always_comb begin
      p_ext = 48'(prod_ff);
      scaled = (p_ext <<< 15) - p_ext;
      r = 17'(((48'(mag_ff) + ROUND_Q30) >> 30));
      if (x_ff > VOL_LIMIT) begin
         x_clamped = VOL_LIMIT;
      end else if (x_ff < -VOL_LIMIT) begin
         x_clamped = -VOL_LIMIT;
      end else begin
         x_clamped = x_ff;
      end
      t = (41'(y_ff) << 12) - 41'(y_ff) + ROUND_Q28;
      v = 13'(t >> 28);
      level = (v > 13'(LEVEL_MAX)) ? LEVEL_MAX : v[DAC_LEVEL_W-1:0];
      if (!job_ff.played) begin
         level = MIDSCALE;
      end
      slot_free = !rsp_valid_ff || rsp_tready;

      state_in = state_ff;
      job_in = job_ff;
      prod_in = prod_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      q_in = q_ff;
      x_in = x_ff;
      y_in = y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dac_in = rsp_dac_ff;
      rsp_played_in = rsp_played_ff;
      rsp_fill_in = rsp_fill_ff;
      queue_pop = 1'b0;

      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               job_in = head_job;
               state_in = BACK_ENV_MUL;
            end
         end
         BACK_ENV_MUL: begin
            prod_in = $signed(job_ff.sample) * $signed({1'b0, job_ff.envelope});
            state_in = BACK_SCALE;
         end
         BACK_SCALE: begin
            neg_in = scaled[47];
            mag_in = 47'(scaled[47] ? -scaled : scaled);
            state_in = BACK_ROUND;
         end
         BACK_ROUND: begin
            if (neg_ff) begin
               q_in = (r >= 17'd32768) ? -16'sd32768 : $signed(16'(17'd0 - r));
            end else begin
               q_in = (r > 17'd32767) ? 16'sd32767 : $signed(r[15:0]);
            end
            state_in = BACK_VOL_MUL;
         end
         BACK_VOL_MUL: begin
            x_in = q_ff * $signed({1'b0, cfg.volume});
            state_in = BACK_CLAMP;
         end
         BACK_CLAMP: begin
            y_in = 29'(x_clamped + HALF_Q27);
            state_in = BACK_LEVEL;
         end
         BACK_LEVEL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_dac_in = DAC_FLAGS | DAC_W'(level);
               rsp_played_in = job_ff.played;
               rsp_fill_in = job_ff.fill;
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, rsp_fill_ff, rsp_dac_ff};
   assign rsp_tuser = rsp_played_ff;
endmodule

>>> sv/audio_playout_fade_dac_formatter.sv
// Top level of the audio playout buffer with fade envelope and DAC word formatter.
// Requests carry a push, a sample tick or a restart in req_tuser and the sample in
// req_tdata; each tick gives one response with the DAC word, the played flag and the
// fill. Pushes, restarts and unknown codes leave the front part idle. A tick holds the
// request port while the sample memory is read and until its job enters a four-entry
// job queue; the back part takes each tick through envelope multiply, scaling, rounding,
// volume multiply, clamp and level conversion, and takes no new tick before it has
// registered the last response. The sample memory needs no clearing after reset. The user
// must write configuration through csr_ only while the block is idle; the block does not enforce it.
module audio_playout_fade_dac_formatter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // sample
   input  logic [1:0]                          req_tuser,   // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,   // dac_word, fill_level, zero pad
   output logic                                rsp_tuser,   // played
   input  logic                                csr_we,
   input  logic [apfdf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [apfdf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import apfdf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic                ram_we;
   logic [PTR_W-1:0]    ram_waddr;
   logic [SAMPLE_W-1:0] ram_wdata;
   logic                ram_re;
   logic [PTR_W-1:0]    ram_raddr;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic                queue_push;
   job_type             queue_job;
   logic                queue_full;
   logic                queue_pop;
   job_type             head_job;
   logic                queue_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PRIME_LEVEL:    cfg_in.prime_level = csr_wdata[LEVEL_W-1:0];
            CSR_LOW_WATER:      cfg_in.low_water = csr_wdata[LEVEL_W-1:0];
            CSR_FADE_UP_STEP:   cfg_in.fade_up_step = csr_wdata[STEP_W-1:0];
            CSR_FADE_DOWN_STEP: cfg_in.fade_down_step = csr_wdata[STEP_W-1:0];
            CSR_VOLUME:         cfg_in.volume = csr_wdata[VOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{prime_level: PRIME_LEVEL_RESET, low_water: LOW_WATER_RESET,
                     fade_up_step: FADE_UP_RESET, fade_down_step: FADE_DOWN_RESET,
                     volume: VOLUME_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   apfdf_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(FIFO_DEPTH)
   ) u_sample_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   apfdf_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .ram_re(ram_re),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata),
      .queue_push(queue_push),
      .queue_job(queue_job),
      .queue_full(queue_full)
   );

   apfdf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(queue_push),
      .push_job(queue_job),
      .pop(queue_pop),
      .head_job(head_job),
      .full(queue_full),
      .empty(queue_empty)
   );

   apfdf_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .head_job(head_job),
      .queue_empty(queue_empty),
      .queue_pop(queue_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );
endmodule
